FILE: rtl/prtt_pkg.sv
// shared types and constants of the pending request timeout table
// no dependencies; used by every module of the block
`default_nettype none

package prtt_pkg;

  localparam int unsigned DepthDefault = 32;

  // request codes
  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_MATCH  = 2'd1,
    REQ_PRUNE  = 2'd2
  } req_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_APPENDED     = 3'd0,
    ST_FULL         = 3'd1,
    ST_FOUND        = 3'd2,
    ST_NOT_FOUND    = 3'd3,
    ST_TIMED_OUT    = 3'd4,
    ST_NONE_EXPIRED = 3'd5
  } status_e;

  // one stored entry
  typedef struct packed {
    logic [31:0] seq;
    logic [63:0] expiry;
    logic [31:0] tag;
  } entry_t;

  // input item
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] seq_number;
    logic [63:0] expiry_time;
    logic [63:0] now_time;
    logic [31:0] reply_tag;
  } req_t;

  // result item
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_seq;
    logic [63:0] out_expiry;
    logic [31:0] out_tag;
    logic [5:0]  entry_count;
    logic        last;
  } rsp_t;

  // cell input select
  typedef enum logic [1:0] {
    SEL_NBR  = 2'd0,
    SEL_HEAD = 2'd1,
    SEL_NEW  = 2'd2
  } cell_sel_e;

  // per-cell control from the sequencer
  typedef struct packed {
    logic      load;
    cell_sel_e sel;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/prtt_cell.sv
// one storage cell of the entry chain
// depends on prtt_pkg (entry_t, cell_ctrl_t)
`default_nettype none

module prtt_cell import prtt_pkg::*; (
  input  wire logic       clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire entry_t     nbr_i,
  input  wire entry_t     head_i,
  input  wire entry_t     new_i,
  output entry_t          entry_o
);

  entry_t entry_q;

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      unique case (ctrl_i.sel)
        SEL_NBR:  entry_q <= nbr_i;
        SEL_HEAD: entry_q <= head_i;
        SEL_NEW:  entry_q <= new_i;
        default:  entry_q <= nbr_i;
      endcase
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

FILE: rtl/pending_request_timeout_table.sv
// pending request timeout table: top level with sequencer and output register
// depends on prtt_pkg and prtt_cell
// append: the result passes through the pending register, then the output register
// match / prune: the chain rotates one cell per cycle, bringing each entry to the head;
//   a prune stalls a step while an earlier timed-out result waits on the output
// one item at a time; the output register lets a result wait while the next item is taken
// reset clears the entry count and control; cell contents are left as they are
`default_nettype none

module pending_request_timeout_table import prtt_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  wire req_t req_i,
  output logic      rsp_valid_o,
  input  wire logic rsp_ready_i,
  output rsp_t      rsp_o
);

  // count width holds 0..DEPTH
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;     // entries held (live length during a scan)
  logic [CW-1:0] rem_q, rem_d;     // entries still to pass the head cell
  logic          prune_q, prune_d;
  logic          found_q, found_d;
  logic          pend_v_q, pend_v_d;
  logic          out_v_q, out_v_d;
  logic [31:0]   key_q, key_d;
  logic [63:0]   now_q, now_d;
  rsp_t          pend_q, pend_d;
  rsp_t          out_q, out_d;

  entry_t     cell_ent [DEPTH];
  cell_ctrl_t cell_ctrl [DEPTH];
  entry_t     head;
  entry_t     new_ent;

  logic accept;
  logic append_ok;
  logic scanning;
  logic hit;
  logic remove;
  logic step;
  logic out_free;

  function automatic rsp_t mk_rsp(status_e st, entry_t e, logic [CW-1:0] cnt, logic lst);
    rsp_t r;
    r.status      = st;
    r.out_seq     = e.seq;
    r.out_expiry  = e.expiry;
    r.out_tag     = e.tag;
    r.entry_count = 6'(cnt);
    r.last        = lst;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // handshake and head-cell decisions
  // ---------------------------------------------------------------------------
  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign append_ok   = accept && (req_i.req_type == REQ_APPEND) && (cnt_q < CW'(DEPTH));

  assign head    = cell_ent[0];
  assign new_ent = '{seq: req_i.seq_number, expiry: req_i.expiry_time, tag: req_i.reply_tag};

  // only the head cell is examined; the chain brings each entry to it in turn
  assign scanning = (state_q == S_SCAN) && (rem_q != '0);
  assign hit      = prune_q ? (head.expiry < now_q) : (!found_q && (head.seq == key_q));
  assign remove   = scanning && hit;
  assign out_free = !out_v_q || rsp_ready_i;
  // a second timed-out result needs the output register for the one held back
  assign step     = scanning && !(remove && pend_v_q && !out_free);

  // ---------------------------------------------------------------------------
  // chain of cells
  // every step shifts toward cell 0; a kept head entry re-enters at the live
  // tail, a removed one is dropped and the live length shrinks, so after all
  // entries have passed the kept ones sit at the front in their old order
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t nbr;

    if (i == DEPTH - 1) begin : g_wrap
      assign nbr = head;
    end else begin : g_mid
      assign nbr = cell_ent[i+1];
    end

    always_comb begin
      cell_ctrl[i].load = (append_ok && (cnt_q == CW'(i))) || step;
      if (append_ok) begin
        cell_ctrl[i].sel = SEL_NEW;
      end else if (!remove && (cnt_q == CW'(i + 1))) begin
        cell_ctrl[i].sel = SEL_HEAD;
      end else begin
        cell_ctrl[i].sel = SEL_NBR;
      end
    end

    prtt_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[i]),
      .nbr_i   (nbr),
      .head_i  (head),
      .new_i   (new_ent),
      .entry_o (cell_ent[i])
    );
  end

  // ---------------------------------------------------------------------------
  // sequencer next state
  // a timed-out result is held in the pending register until the next removal
  // or the end of the scan tells whether it is the last one
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    prune_d  = prune_q;
    found_d  = found_q;
    pend_v_d = pend_v_q;
    out_v_d  = out_v_q;
    key_d    = key_q;
    now_d    = now_q;
    pend_d   = pend_q;
    out_d    = out_q;

    // output transfer frees the register
    if (out_v_q && rsp_ready_i) begin
      out_v_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.req_type)
            REQ_APPEND: begin
              if (append_ok) begin
                cnt_d  = cnt_q + 1'b1;
                pend_d = mk_rsp(ST_APPENDED, '0, cnt_q + 1'b1, 1'b1);
              end else begin
                pend_d = mk_rsp(ST_FULL, '0, cnt_q, 1'b1);
              end
              pend_v_d = 1'b1;
              state_d  = S_DRAIN;
            end
            REQ_MATCH, REQ_PRUNE: begin
              prune_d  = (req_i.req_type == REQ_PRUNE);
              key_d    = req_i.seq_number;
              now_d    = req_i.now_time;
              rem_d    = cnt_q;
              found_d  = 1'b0;
              pend_v_d = 1'b0;
              state_d  = S_SCAN;
            end
            default: ;  // unused code: ignored, no result
          endcase
        end
      end

      S_SCAN: begin
        if (rem_q == '0) begin
          // every entry has passed the head
          if (prune_q) begin
            if (pend_v_q) begin
              pend_d.last = 1'b1;
            end else begin
              pend_d = mk_rsp(ST_NONE_EXPIRED, '0, cnt_q, 1'b1);
            end
          end else if (!found_q) begin
            pend_d = mk_rsp(ST_NOT_FOUND, '0, cnt_q, 1'b1);
          end
          pend_v_d = 1'b1;
          state_d  = S_DRAIN;
        end else if (step) begin
          rem_d = rem_q - 1'b1;
          if (remove) begin
            cnt_d    = cnt_q - 1'b1;
            found_d  = 1'b1;
            pend_d   = mk_rsp(prune_q ? ST_TIMED_OUT : ST_FOUND, head,
                              cnt_q - 1'b1, !prune_q);
            pend_v_d = 1'b1;
            // earlier timed-out result was not the last
            if (pend_v_q) begin
              out_d   = pend_q;
              out_v_d = 1'b1;
            end
          end
        end
      end

      S_DRAIN: begin
        if (out_free) begin
          out_d    = pend_q;
          out_v_d  = 1'b1;
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rem_q    <= '0;
      prune_q  <= 1'b0;
      found_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      prune_q  <= prune_d;
      found_q  <= found_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    now_q  <= now_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign rsp_valid_o = out_v_q;
  assign rsp_o       = out_q;

endmodule

`default_nettype wire

FILE: rtl/prtt_checker.sv
// port-level checks for the pending request timeout table, bound to the top level
// depends on prtt_pkg and pending_request_timeout_table
`default_nettype none

module prtt_checker import prtt_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_ready_o,
  input wire logic rsp_valid_o,
  input wire logic rsp_ready_i,
  input wire rsp_t rsp_o
);

  // a stalled result stays
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> $stable(rsp_o))
    else $error("result changed while stalled");

  // a non-final result means the item is still in progress
  a_busy_mid_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.last |-> !req_ready_o)
    else $error("new transfer taken while an item still has results to give");

  // results that carry no entry are single and zero
  a_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.status == ST_APPENDED || rsp_o.status == ST_FULL ||
                    rsp_o.status == ST_NOT_FOUND || rsp_o.status == ST_NONE_EXPIRED)
    |-> rsp_o.last && rsp_o.out_seq == '0 && rsp_o.out_expiry == '0 &&
        rsp_o.out_tag == '0)
    else $error("entry-less result not final or not zero");

endmodule

bind pending_request_timeout_table prtt_checker u_prtt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_o (req_ready_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);

`default_nettype wire
